### rtl/crcr_pkg.sv
// Package for the cell refraction coordinate remap block.
// Holds field widths, register indexes, the per-axis config struct and
// the width helpers that crcr_axis and the top level use.
`default_nettype none

package crcr_pkg;

    localparam int POS_W      = 11;
    localparam int IDX_W      = 22;
    localparam int CELL_W     = 8;
    localparam int HALF_W     = 7;
    localparam int FACTOR_W   = 13;
    localparam int FRAME_W    = 12;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_W     = 10;
    localparam int DIV_BITS   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 13'd256;

    localparam logic [CFG_IDX_W-1:0] REG_REFRACTION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_MAG  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H    = 8'd5;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_size;
        logic [HALF_W-1:0]   half_cell;
        logic [FACTOR_W-1:0] factor;
    } crcr_axis_cfg_t;

    // Width of the dividend magnitude: covers a full coordinate plus two half cells.
    function automatic int crcr_aw(input int max_dim);
        int lg;
        lg = $clog2(max_dim);
        return ((lg > 12) ? lg : 12) + 1;
    endfunction

    function automatic int crcr_div_stages(input int aw);
        return (aw + DIV_BITS - 1) / DIV_BITS;
    endfunction

endpackage

`default_nettype wire

### rtl/crcr_div_stage.sv
// One pipeline stage of the remainder divider: DIV_BITS restoring steps.
// Depends on crcr_pkg; carries side payload along with the partial remainder.
`default_nettype none

module crcr_div_stage
    import crcr_pkg::*;
#(
    parameter int AWP    = 16,
    parameter int SIDE_W = 28
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [CELL_W-1:0] cell_size,
    input  wire logic [CELL_W-1:0] rem_in,
    input  wire logic [AWP-1:0]    dvd_in,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic      [CELL_W-1:0] rem_out,
    output logic      [AWP-1:0]    dvd_out,
    output logic      [SIDE_W-1:0] side_out
);

    logic [CELL_W-1:0] rem_next;
    logic [AWP-1:0]    dvd_next;
    logic [CELL_W-1:0] rem_reg;
    logic [AWP-1:0]    dvd_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        logic [CELL_W:0] trial;
        rem_next = rem_in;
        dvd_next = dvd_in;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, dvd_next[AWP-1]};
            dvd_next = dvd_next << 1;
            if (trial >= {1'b0, cell_size})
            begin
                rem_next = CELL_W'(trial - {1'b0, cell_size});
            end
            else
            begin
                rem_next = trial[CELL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign dvd_out  = dvd_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

### rtl/crcr_axis.sv
// Remap pipeline for one axis: centering, cell remainder, scaling and clamp.
// Depends on crcr_pkg and crcr_div_stage; stage enables come from the top level.
`default_nettype none

module crcr_axis
    import crcr_pkg::*;
#(
    parameter int MAX_DIM = 2048,
    localparam int DW     = $clog2(MAX_DIM + 1),
    localparam int XW     = $clog2(MAX_DIM),
    localparam int DS     = crcr_div_stages(crcr_aw(MAX_DIM)),
    localparam int NA     = DS + 7
)
(
    input  wire logic           clk,
    input  wire logic [NA-1:0]  en,
    input  wire crcr_axis_cfg_t cfg,
    input  wire logic [DW-1:0]  dim,
    input  wire logic [POS_W-1:0] pos,
    output logic      [XW-1:0]  coord
);

    localparam int AW     = crcr_aw(MAX_DIM);
    localparam int AWP    = DS * DIV_BITS;
    localparam int NW     = AW + 1;
    localparam int SW     = AW + 3;
    localparam int SIDE_W = NW + 1 + AW;
    localparam int PROD_W = DIST_W + FACTOR_W + 1;

    logic [DW-2:0]          half_dim;
    logic signed [NW-1:0]   hc_s;
    logic [DW-1:0]          dim_m1;

    assign half_dim = dim[DW-1:1];
    assign hc_s     = $signed({{(NW-HALF_W){1'b0}}, cfg.half_cell});
    assign dim_m1   = dim - DW'(1);

    // Stage 0: coordinate centred on the frame and offset by half a cell.
    logic signed [NW-1:0] n0_next, n0_reg;

    assign n0_next = $signed({{(NW-POS_W){1'b0}}, pos})
                   - $signed({{(NW-DW+1){1'b0}}, half_dim}) + hc_s;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n0_reg <= n0_next;
        end
    end

    // Stage 1: magnitude of the dividend; its sign follows the centred coordinate.
    logic signed [NW-1:0] mag_wide;
    logic [AW-1:0]        a1_next, a1_reg;
    logic                 neg1_next, neg1_reg;
    logic signed [NW-1:0] n1_reg;

    assign neg1_next = n0_reg[NW-1];
    assign mag_wide  = neg1_next ? (hc_s - n0_reg) : (n0_reg + hc_s);
    assign a1_next   = mag_wide[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            n1_reg   <= n0_reg;
            neg1_reg <= neg1_next;
            a1_reg   <= a1_next;
        end
    end

    // Divider stages: only the remainder of the magnitude by the cell size is needed.
    logic [CELL_W-1:0] rem_w  [0:DS];
    logic [AWP-1:0]    dvd_w  [0:DS];
    logic [SIDE_W-1:0] side_w [0:DS];

    assign rem_w[0]  = '0;
    assign dvd_w[0]  = AWP'(a1_reg);
    assign side_w[0] = {n1_reg, neg1_reg, a1_reg};

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        crcr_div_stage #(
            .AWP    (AWP),
            .SIDE_W (SIDE_W)
        ) u_div_stage (
            .clk       (clk),
            .en        (en[k+2]),
            .cell_size (cfg.cell_size),
            .rem_in    (rem_w[k]),
            .dvd_in    (dvd_w[k]),
            .side_in   (side_w[k]),
            .rem_out   (rem_w[k+1]),
            .dvd_out   (dvd_w[k+1]),
            .side_out  (side_w[k+1])
        );
    end

    logic signed [NW-1:0] n_d;
    logic                 neg_d;
    logic [AW-1:0]        a_d;

    assign n_d   = $signed(side_w[DS][SIDE_W-1 -: NW]);
    assign neg_d = side_w[DS][AW];
    assign a_d   = side_w[DS][AW-1:0];

    // Stage C1: signed multiple of the cell size that truncating division gives.
    logic signed [NW-1:0] a_s, r_s;
    logic signed [NW-1:0] qc_next, qc_reg, nc_reg;

    assign a_s     = $signed({1'b0, a_d});
    assign r_s     = $signed({{(NW-CELL_W){1'b0}}, rem_w[DS]});
    assign qc_next = neg_d ? (r_s - a_s) : (a_s - r_s);

    always_ff @(posedge clk)
    begin
        if (en[DS+2])
        begin
            qc_reg <= qc_next;
            nc_reg <= n_d;
        end
    end

    // Stage C2: cell centre and distance from it.
    logic signed [NW-1:0]     centre_next, centre_reg, dist_wide;
    logic signed [DIST_W-1:0] dist_reg;

    assign centre_next = qc_reg + hc_s;
    assign dist_wide   = nc_reg - qc_reg - hc_s;

    always_ff @(posedge clk)
    begin
        if (en[DS+3])
        begin
            centre_reg <= centre_next;
            dist_reg   <= dist_wide[DIST_W-1:0];
        end
    end

    // Stage M: distance times the 5.8 factor.
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [NW-1:0]     centre_m_reg;

    assign prod_next = dist_reg * $signed({1'b0, cfg.factor});

    always_ff @(posedge clk)
    begin
        if (en[DS+4])
        begin
            prod_reg     <= prod_next;
            centre_m_reg <= centre_reg;
        end
    end

    // Stage F: flooring shift and return to frame coordinates.
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [SW-1:0]     src_next, src_reg;

    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign src_next = SW'(prod_sh) + SW'(centre_m_reg)
                    + $signed({{(SW-DW+1){1'b0}}, half_dim});

    always_ff @(posedge clk)
    begin
        if (en[DS+5])
        begin
            src_reg <= src_next;
        end
    end

    // Stage K: clamp into the frame.
    logic signed [SW-1:0] dim_m1_s;
    logic [XW-1:0]        coord_next, coord_reg;

    assign dim_m1_s = $signed({{(SW-DW){1'b0}}, dim_m1});

    always_comb
    begin
        priority if (src_reg[SW-1])
        begin
            coord_next = '0;
        end
        else if (src_reg > dim_m1_s)
        begin
            coord_next = dim_m1[XW-1:0];
        end
        else
        begin
            coord_next = src_reg[XW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DS+6])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

### rtl/cell_refraction_coordinate_remap.sv
// Cell refraction coordinate remap, top level.
// Depends on crcr_pkg, crcr_axis and crcr_div_stage.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one output pixel position per transfer;
//   m_tvalid/m_tready/m_tdata return its source column, row and linear index.
//   The cfg_* channel writes one configuration register per transfer; it is
//   always ready and should be used only while no pixel is in flight.
// Pipeline depth: DS is the number of remainder divider stages (4 at
//   MAX_DIM = 2048). The depth is set by the pipelined cell-size
//   remainder divider, four restoring steps per stage, followed by the
//   scale multiplier, clamp and linear index registers.
// Throughput: one pixel per cycle sustained while m_tready stays high.
// Reset: all pipeline valid bits clear and the registers return to factor
//   2.0, magnification allowed, 16 x 16 cells and a 640 x 480 frame.
// Stall: when m_tready is low, the result holds in the output register and
//   the stages behind it keep filling their empty slots; s_tready drops
//   only once every stage holds an item.
`default_nettype none

module cell_refraction_coordinate_remap
    import crcr_pkg::*;
#(
    parameter int MAX_DIM = 2048
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream, tdata: out_col [10:0], out_row [21:11], zero [23:22].
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Output stream, tdata: src_col [10:0], src_row [21:11],
    // src_index [43:22], zero [47:44].
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int XW = $clog2(MAX_DIM);
    localparam int CW = (DW > FRAME_W) ? DW : FRAME_W;
    localparam int DS = crcr_div_stages(crcr_aw(MAX_DIM));
    localparam int NA = DS + 7;
    localparam int NS = NA + 2;
    localparam int IW = XW + DW;

    // Configuration registers.
    logic [FACTOR_W-1:0] refraction_reg;
    logic                allow_mag_reg;
    logic [CELL_W-1:0]   cell_w_reg, cell_h_reg;
    logic [FRAME_W-1:0]  frame_w_reg, frame_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refraction_reg <= 13'd512;
            allow_mag_reg  <= 1'b1;
            cell_w_reg     <= 8'd16;
            cell_h_reg     <= 8'd16;
            frame_w_reg    <= 12'd640;
            frame_h_reg    <= 12'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REFRACTION: refraction_reg <= cfg_data[FACTOR_W-1:0];
                REG_ALLOW_MAG:  allow_mag_reg  <= cfg_data[0];
                REG_CELL_W:     cell_w_reg     <= cfg_data[CELL_W-1:0];
                REG_CELL_H:     cell_h_reg     <= cfg_data[CELL_W-1:0];
                REG_FRAME_W:    frame_w_reg    <= cfg_data[FRAME_W-1:0];
                REG_FRAME_H:    frame_h_reg    <= cfg_data[FRAME_W-1:0];
                default:        ;
            endcase
        end
    end

    // Effective settings: zero sizes act as one, frames clamp to MAX_DIM.
    logic [FACTOR_W-1:0] factor_eff;
    logic [CELL_W-1:0]   cell_w_eff, cell_h_eff;
    logic [CW-1:0]       frame_w_ext, frame_h_ext;
    logic [DW-1:0]       dim_w, dim_h;
    crcr_axis_cfg_t      cfg_col, cfg_row;

    assign factor_eff = (!allow_mag_reg && (refraction_reg < FACTOR_ONE))
                      ? FACTOR_ONE : refraction_reg;
    assign cell_w_eff = (cell_w_reg == '0) ? CELL_W'(1) : cell_w_reg;
    assign cell_h_eff = (cell_h_reg == '0) ? CELL_W'(1) : cell_h_reg;
    assign frame_w_ext = CW'(frame_w_reg);
    assign frame_h_ext = CW'(frame_h_reg);

    always_comb
    begin
        priority if (frame_w_ext == '0)
        begin
            dim_w = DW'(1);
        end
        else if (frame_w_ext > CW'(MAX_DIM))
        begin
            dim_w = DW'(MAX_DIM);
        end
        else
        begin
            dim_w = frame_w_ext[DW-1:0];
        end
        priority if (frame_h_ext == '0)
        begin
            dim_h = DW'(1);
        end
        else if (frame_h_ext > CW'(MAX_DIM))
        begin
            dim_h = DW'(MAX_DIM);
        end
        else
        begin
            dim_h = frame_h_ext[DW-1:0];
        end
    end

    assign cfg_col = '{cell_size: cell_w_eff, half_cell: cell_w_eff[CELL_W-1:1],
                       factor: factor_eff};
    assign cfg_row = '{cell_size: cell_h_eff, half_cell: cell_h_eff[CELL_W-1:1],
                       factor: factor_eff};

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NS-1];

    // Axis pipelines.
    logic [XW-1:0] sx, sy;

    crcr_axis #(
        .MAX_DIM (MAX_DIM)
    ) u_axis_col (
        .clk   (clk),
        .en    (en[NA-1:0]),
        .cfg   (cfg_col),
        .dim   (dim_w),
        .pos   (s_tdata[POS_W-1:0]),
        .coord (sx)
    );

    crcr_axis #(
        .MAX_DIM (MAX_DIM)
    ) u_axis_row (
        .clk   (clk),
        .en    (en[NA-1:0]),
        .cfg   (cfg_row),
        .dim   (dim_h),
        .pos   (s_tdata[2*POS_W-1:POS_W]),
        .coord (sy)
    );

    // Linear index: row times width, then plus column.
    logic [IW-1:0] rowoff_next, rowoff_reg;
    logic [XW-1:0] sx_reg, sy_reg;
    logic [IW-1:0] idx_next;
    logic [OUT_DATA_W-1:0] out_next, out_reg;

    assign rowoff_next = IW'(sy) * IW'(dim_w);

    always_ff @(posedge clk)
    begin
        if (en[NA])
        begin
            rowoff_reg <= rowoff_next;
            sx_reg     <= sx;
            sy_reg     <= sy;
        end
    end

    assign idx_next = rowoff_reg + IW'(sx_reg);
    assign out_next = {4'b0, IDX_W'(idx_next), POS_W'(sy_reg), POS_W'(sx_reg)};

    always_ff @(posedge clk)
    begin
        if (en[NA+1])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire
